/* sv/iepp_pkg.sv */
`default_nettype none

package iepp_pkg;

   // Byte counter width and its saturation value
   localparam int LENGTH_BITS = 16;
   localparam int COUNT_BITS  = LENGTH_BITS + 1;
   localparam logic [16:0] LENGTH_MAX = 17'((17'd1 << LENGTH_BITS) - 17'd1);

   // Header sizes and field values
   localparam logic [3:0] IPV4_VERSION  = 4'd4;
   localparam logic [3:0] IPV4_MIN_IHL  = 4'd5;
   localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
   localparam int         ICMP_HDR      = 8;
   localparam logic [7:0] ICMP4_ECHO_REQ   = 8'd8;
   localparam logic [7:0] ICMP4_ECHO_REPLY = 8'd0;
   localparam logic [7:0] ICMP6_ECHO_REQ   = 8'd128;
   localparam logic [7:0] V6_ECHO_REPLY    = 8'd129;

   // Byte offsets within the IPv4 header
   localparam int IP_OFS_VER_IHL  = 0;
   localparam int IP_OFS_TLEN_HI  = 2;
   localparam int IP_OFS_TLEN_LO  = 3;
   localparam int IP_OFS_FIRST_PL = 4;
   localparam int IP_OFS_PROTO    = 9;

   // Offsets within the ICMP header
   localparam logic [2:0] ICMP_OFS_TYPE   = 3'd0;
   localparam logic [2:0] ICMP_OFS_CODE   = 3'd1;
   localparam logic [2:0] ICMP_OFS_CSUM_H = 3'd2;
   localparam logic [2:0] ICMP_OFS_CSUM_L = 3'd3;
   localparam logic [2:0] ICMP_OFS_ID_H   = 3'd4;
   localparam logic [2:0] ICMP_OFS_ID_L   = 3'd5;
   localparam logic [2:0] ICMP_OFS_SEQ_H  = 3'd6;
   localparam logic [2:0] ICMP_OFS_SEQ_L  = 3'd7;

   // Mode register codes
   localparam logic MODE_IPV4 = 1'b0;
   localparam logic MODE_IPV6 = 1'b1;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   // One result item
   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  payload_byte;
      logic        accepted;
      logic [7:0]  message_type;
      logic [7:0]  message_code;
      logic [15:0] message_checksum;
      logic [15:0] echo_ident;
      logic [15:0] echo_sequence;
      logic [15:0] payload_length;
      logic        length_mismatch;
      logic        last_of_run;
   } result_type;

   localparam int RSP_DATA_BITS = 96;
   localparam int QUEUE_DEPTH   = 3;

endpackage

`default_nettype wire

/* sv/icmp_echo_packet_parser_core.sv */
`default_nettype none
// With the result queue empty, a result item appears on rsp_ in the cycle after its
// packet byte is taken.
// Throughput: one packet byte per cycle while req_tready is high. The last byte of a
// packet that also carries payload yields two result items on rsp_; a three-entry result
// queue absorbs that, req_tready is high while it holds one or none, so the next byte waits.
// Reset: synchronous; selects IPv4 mode, clears packet state and empties the queue.

module icmp_echo_packet_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,   // ip_version_mode
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,        // [7:0] packet_byte
   input  wire logic        req_tlast,        // end_of_packet
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [iepp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
      // [7:0] payload_byte, [8] accepted, [16:9] message_type, [24:17] message_code,
      // [40:25] message_checksum, [56:41] echo_ident, [72:57] echo_sequence,
      // [88:73] payload_length, [89] length_mismatch, [95:90] zero
   output logic             rsp_tuser,        // result_kind
   output logic             rsp_tlast         // last_of_run
);
   import iepp_pkg::*;

   logic                   mode_ff;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [15:0]            tlen_ff, tlen_in;
   logic [5:0]             ihl_bytes_ff, ihl_bytes_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             type_ff, type_in, code_ff, code_in;
   logic [15:0]            csum_ff, csum_in, ident_ff, ident_in, seq_ff, seq_in;

   result_type             queue_ff [QUEUE_DEPTH];
   result_type             queue_in [QUEUE_DEPTH];
   logic [1:0]             count_ff, count_in;

   logic                   take, pop, v6, last;
   logic [7:0]             b;
   logic [6:0]             hdr_end;
   logic [LENGTH_BITS-1:0] ofs_diff;
   logic                   cap_en;
   logic [2:0]             cap_ofs;
   logic                   emit, acc;
   logic [COUNT_BITS-1:0]  count_rx;
   logic [6:0]             need;
   result_type             res_pay, res_sum, res0, res1;
   logic [1:0]             n_res, base;

   assign take = req_tvalid && req_tready;
   assign pop  = rsp_tvalid && rsp_tready;
   assign v6   = (mode_ff == MODE_IPV6);
   assign b    = req_tdata;
   assign last = req_tlast;

   assign hdr_end  = 7'(ihl_bytes_ff) + 7'(ICMP_HDR);
   assign ofs_diff = pos_ff - LENGTH_BITS'(ihl_bytes_ff);
   assign count_rx = COUNT_BITS'(pos_ff) + COUNT_BITS'(1);

   // Header checks and field capture for the byte at hand
   always_comb begin
      tlen_in      = tlen_ff;
      ihl_bytes_in = ihl_bytes_ff;
      valid_in     = valid_ff;
      cap_en       = 1'b0;
      cap_ofs      = pos_ff[2:0];
      emit         = 1'b0;
      if (!v6) begin
         if (pos_ff == LENGTH_BITS'(IP_OFS_VER_IHL)) begin
            if (b[7:4] != IPV4_VERSION || b[3:0] < IPV4_MIN_IHL) begin
               valid_in = 1'b0;
            end
            ihl_bytes_in = {b[3:0], 2'b00};
         end else begin
            if (pos_ff == LENGTH_BITS'(IP_OFS_TLEN_HI)) begin
               tlen_in = {b, tlen_ff[7:0]};
            end
            if (pos_ff == LENGTH_BITS'(IP_OFS_TLEN_LO)) begin
               tlen_in = {tlen_ff[15:8], b};
               if (tlen_in < 16'(hdr_end) || 17'(tlen_in) > LENGTH_MAX) begin
                  valid_in = 1'b0;
               end
            end
            if (pos_ff == LENGTH_BITS'(IP_OFS_PROTO) && b != IP_PROTO_ICMP) begin
               valid_in = 1'b0;
            end
            if (pos_ff >= LENGTH_BITS'(ihl_bytes_ff) && pos_ff < LENGTH_BITS'(hdr_end)) begin
               cap_en  = 1'b1;
               cap_ofs = ofs_diff[2:0];
               if (cap_ofs == ICMP_OFS_TYPE && b != ICMP4_ECHO_REQ && b != ICMP4_ECHO_REPLY) begin
                  valid_in = 1'b0;
               end
            end
            emit = pos_ff >= LENGTH_BITS'(IP_OFS_FIRST_PL) && pos_ff >= LENGTH_BITS'(hdr_end)
                   && 16'(pos_ff) < tlen_in && valid_in;
         end
      end else begin
         if (pos_ff < LENGTH_BITS'(ICMP_HDR)) begin
            cap_en = 1'b1;
            if (pos_ff[2:0] == ICMP_OFS_TYPE && b != ICMP6_ECHO_REQ
                && b != V6_ECHO_REPLY) begin
               valid_in = 1'b0;
            end
         end else begin
            emit = valid_ff;
         end
      end
   end

   // Capture ICMP header fields
   always_comb begin
      type_in  = type_ff;
      code_in  = code_ff;
      csum_in  = csum_ff;
      ident_in = ident_ff;
      seq_in   = seq_ff;
      if (cap_en) begin
         case (cap_ofs)
            ICMP_OFS_TYPE:   type_in  = b;
            ICMP_OFS_CODE:   code_in  = b;
            ICMP_OFS_CSUM_H: csum_in  = {b, csum_ff[7:0]};
            ICMP_OFS_CSUM_L: csum_in  = {csum_ff[15:8], b};
            ICMP_OFS_ID_H:   ident_in = {b, ident_ff[7:0]};
            ICMP_OFS_ID_L:   ident_in = {ident_ff[15:8], b};
            ICMP_OFS_SEQ_H:  seq_in   = {b, seq_ff[7:0]};
            default:         seq_in   = {seq_ff[15:8], b};
         endcase
      end
   end

   // Build the payload and summary items
   always_comb begin
      need = v6 ? 7'(ICMP_HDR) : (7'(ihl_bytes_in) + 7'(ICMP_HDR));
      acc  = valid_in && count_rx >= COUNT_BITS'(need)
             && (v6 || pos_ff >= LENGTH_BITS'(IP_OFS_FIRST_PL));

      res_pay              = '0;
      res_pay.result_kind  = KIND_PAYLOAD;
      res_pay.payload_byte = b;
      res_pay.last_of_run  = !last;

      res_sum             = '0;
      res_sum.result_kind = KIND_SUMMARY;
      res_sum.last_of_run = 1'b1;
      if (acc) begin
         res_sum.accepted         = 1'b1;
         res_sum.message_type     = type_in;
         res_sum.message_code     = code_in;
         res_sum.message_checksum = csum_in;
         res_sum.echo_ident       = ident_in;
         res_sum.echo_sequence    = seq_in;
         if (v6) begin
            res_sum.payload_length = 16'(17'(count_rx) - 17'(ICMP_HDR));
         end else begin
            res_sum.payload_length  = tlen_in - 16'(ihl_bytes_in) - 16'(ICMP_HDR);
            res_sum.length_mismatch = (17'(count_rx) != 17'(tlen_in));
         end
      end

      res0  = emit ? res_pay : res_sum;
      res1  = res_sum;
      n_res = take ? (2'(emit) + 2'(last)) : 2'd0;
   end

   // Advance the byte position up to LENGTH_MAX; packet state is cleared after the last byte
   always_comb begin
      pos_in = pos_ff;
      if (!last && 17'(pos_ff) < LENGTH_MAX) begin
         pos_in = pos_ff + LENGTH_BITS'(1);
      end
   end

   // Shift the queue on a pop and append new items behind what remains
   always_comb begin
      base = count_ff - 2'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_in[i] = (pop && i < QUEUE_DEPTH - 1) ? queue_ff[(i + 1) % QUEUE_DEPTH]
                                                    : queue_ff[i];
         if (n_res != 2'd0 && 2'(i) == base) begin
            queue_in[i] = res0;
         end
         if (n_res == 2'd2 && 2'(i) == base + 2'd1) begin
            queue_in[i] = res1;
         end
      end
      count_in = base + n_res;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IPV4;
         pos_ff       <= '0;
         tlen_ff      <= '0;
         ihl_bytes_ff <= '0;
         valid_ff     <= 1'b1;
         type_ff      <= '0;
         code_ff      <= '0;
         csum_ff      <= '0;
         ident_ff     <= '0;
         seq_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (take) begin
            if (last) begin
               pos_ff       <= '0;
               tlen_ff      <= '0;
               ihl_bytes_ff <= '0;
               valid_ff     <= 1'b1;
               type_ff      <= '0;
               code_ff      <= '0;
               csum_ff      <= '0;
               ident_ff     <= '0;
               seq_ff       <= '0;
            end else begin
               pos_ff       <= pos_in;
               tlen_ff      <= tlen_in;
               ihl_bytes_ff <= ihl_bytes_in;
               valid_ff     <= valid_in;
               type_ff      <= type_in;
               code_ff      <= code_in;
               csum_ff      <= csum_in;
               ident_ff     <= ident_in;
               seq_ff       <= seq_in;
            end
         end
         count_ff <= count_in;
      end
   end

   // Queue payload, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   // Drive the ports
   assign req_tready = (count_ff <= 2'd1);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser  = queue_ff[0].result_kind;
   assign rsp_tlast  = queue_ff[0].last_of_run;
   assign rsp_tdata  = {6'd0,
                        queue_ff[0].length_mismatch,
                        queue_ff[0].payload_length,
                        queue_ff[0].echo_sequence,
                        queue_ff[0].echo_ident,
                        queue_ff[0].message_checksum,
                        queue_ff[0].message_code,
                        queue_ff[0].message_type,
                        queue_ff[0].accepted,
                        queue_ff[0].payload_byte};

   // Packet state returns to its start after the last byte
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take && last |=> pos_ff == '0 && valid_ff && ihl_bytes_ff == '0)
      else $error("packet state not cleared after last byte");

   // A payload item carries nothing beyond its byte
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RSP_DATA_BITS-1:8] == '0)
      else $error("payload item carries summary fields");

   // A summary closes its run, and a rejected one is all zero
   a_summary_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[8] || rsp_tdata == '0))
      else $error("malformed summary item");

   // A stalled result item holds still until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("stalled result item changed");

endmodule

`default_nettype wire
